@@ hw/rtl/lc3ex_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3ex_pkg
// Shared types and constants for the LC-3 execute core: opcodes, condition
// code bits and the execute result bundle.
// ----------------------------------------------------------------------------
package lc3ex_pkg;

  localparam int unsigned XLEN     = 16;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned RIDX_W   = 3;
  localparam int unsigned CC_W     = 3;

  localparam logic [XLEN-1:0]   RESET_PC = 16'h3000;
  localparam logic [RIDX_W-1:0] LINK_REG = 3'd7;

  localparam logic [CC_W-1:0] FLAG_P = 3'b001;
  localparam logic [CC_W-1:0] FLAG_Z = 3'b010;
  localparam logic [CC_W-1:0] FLAG_N = 3'b100;

  typedef enum logic [3:0] {
    OP_BR   = 4'h0,
    OP_ADD  = 4'h1,
    OP_LD   = 4'h2,
    OP_ST   = 4'h3,
    OP_JSR  = 4'h4,
    OP_AND  = 4'h5,
    OP_LDR  = 4'h6,
    OP_STR  = 4'h7,
    OP_RTI  = 4'h8,
    OP_NOT  = 4'h9,
    OP_LDI  = 4'hA,
    OP_STI  = 4'hB,
    OP_JMP  = 4'hC,
    OP_RES  = 4'hD,
    OP_LEA  = 4'hE,
    OP_TRAP = 4'hF
  } opcode_t;

  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              status;
    logic              wrote;
    logic [RIDX_W-1:0] widx;
    logic [XLEN-1:0]   wval;
    logic [CC_W-1:0]   cc;
  } ex_result_t;

endpackage
`default_nettype wire

@@ hw/rtl/lc3ex_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3ex_exec
// Combinational execute unit: decodes one instruction word against its
// register operands, the program counter and the condition code.
// ----------------------------------------------------------------------------
module lc3ex_exec (
  input  wire logic [lc3ex_pkg::XLEN-1:0] instr,
  input  wire logic [lc3ex_pkg::XLEN-1:0] src1,
  input  wire logic [lc3ex_pkg::XLEN-1:0] src2,
  input  wire logic [lc3ex_pkg::XLEN-1:0] pc,
  input  wire logic [lc3ex_pkg::CC_W-1:0] cc,
  output lc3ex_pkg::ex_result_t           res
);
  import lc3ex_pkg::*;

  opcode_t           op;
  logic [XLEN-1:0]   pc_inc;
  logic [XLEN-1:0]   off9;
  logic [XLEN-1:0]   off11;
  logic [XLEN-1:0]   imm5;
  logic [XLEN-1:0]   operand;
  logic [RIDX_W-1:0] dr;

  assign op      = opcode_t'(instr[15:12]);
  assign dr      = instr[11:9];
  assign pc_inc  = pc + 16'd1;
  assign off9    = {{7{instr[8]}}, instr[8:0]};
  assign off11   = {{5{instr[10]}}, instr[10:0]};
  assign imm5    = {{11{instr[4]}}, instr[4:0]};
  assign operand = instr[5] ? imm5 : src2;

  always_comb begin
    res         = '0;
    res.next_pc = pc_inc;
    res.cc      = cc;
    case (op)
      OP_BR: begin
        if (|(dr & cc)) begin
          res.next_pc = pc_inc + off9;
        end
      end
      OP_ADD: begin
        res.wrote = 1'b1;
        res.widx  = dr;
        res.wval  = src1 + operand;
      end
      OP_AND: begin
        res.wrote = 1'b1;
        res.widx  = dr;
        res.wval  = src1 & operand;
      end
      OP_NOT: begin
        res.wrote = 1'b1;
        res.widx  = dr;
        res.wval  = ~src1;
      end
      OP_JMP: begin
        res.next_pc = src1;
      end
      OP_JSR: begin
        // return address goes to the link register, base read beforehand
        res.wrote   = 1'b1;
        res.widx    = LINK_REG;
        res.wval    = pc_inc;
        res.next_pc = instr[11] ? (pc_inc + off11) : src1;
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
    // flags follow the written value, except for the link write
    if (res.wrote && (op != OP_JSR)) begin
      if (res.wval == '0) begin
        res.cc = FLAG_Z;
      end else if (res.wval[XLEN-1]) begin
        res.cc = FLAG_N;
      end else begin
        res.cc = FLAG_P;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/lc3_execute_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3_execute_core
// LC-3 execute core: takes instruction words, runs BR/ADD/AND/NOT/JMP/JSR
// against eight general registers, PC and N/Z/P flags, reports each step.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_ready   | instruction_word
//  out     | out_valid / out_ready | next_pc, status, wrote_register,
//          |                       | dest_index, dest_value, cond_flags
//  cfg     | cfg_valid / cfg_ready | start_address (also loads the pc)
//
//  one item per cycle sustained while out_ready holds; a taken item passes the
//  operand register, then execute into the result register
//  register reads are bypassed from the instruction executing in the same cycle
//  reset loads the pc with 0x3000, clears flags and marks all registers zero
//  a stalled result holds the execute stage, which then holds the input side
// ----------------------------------------------------------------------------
module lc3_execute_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [lc3ex_pkg::XLEN-1:0]   instruction_word,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [lc3ex_pkg::XLEN-1:0]        next_pc,
  output logic                              status,
  output logic                              wrote_register,
  output logic [lc3ex_pkg::RIDX_W-1:0]      dest_index,
  output logic [lc3ex_pkg::XLEN-1:0]        dest_value,
  output logic [lc3ex_pkg::CC_W-1:0]        cond_flags,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [lc3ex_pkg::XLEN-1:0]   start_address
);
  import lc3ex_pkg::*;

  // architectural state
  logic [XLEN-1:0]     regs [NUM_REGS];
  logic [NUM_REGS-1:0] reg_vld;
  logic [XLEN-1:0]     pc;
  logic [CC_W-1:0]     cc;

  // operand stage
  logic              s1_valid;
  logic [XLEN-1:0]   s1_instr;
  logic [XLEN-1:0]   rd1;
  logic [XLEN-1:0]   rd2;
  logic              rd1_vld;
  logic              rd2_vld;
  logic              rd1_fwd;
  logic              rd2_fwd;
  logic [XLEN-1:0]   fwd_val;

  logic              in_fire;
  logic              ex_fire;
  logic              out_free;
  logic              ex_write;
  logic [RIDX_W-1:0] in_sr1;
  logic [RIDX_W-1:0] in_sr2;
  logic [XLEN-1:0]   src1;
  logic [XLEN-1:0]   src2;
  ex_result_t        ex_res;

  assign out_free  = !out_valid || out_ready;
  assign ex_fire   = s1_valid && out_free;
  assign in_ready  = !rst && (!s1_valid || ex_fire);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = !rst;
  assign ex_write  = ex_fire && ex_res.wrote;
  assign in_sr1    = instruction_word[8:6];
  assign in_sr2    = instruction_word[2:0];

  assign src1 = rd1_fwd ? fwd_val : (rd1_vld ? rd1 : '0);
  assign src2 = rd2_fwd ? fwd_val : (rd2_vld ? rd2 : '0);

  lc3ex_exec u_exec (
    .instr (s1_instr),
    .src1  (src1),
    .src2  (src2),
    .pc    (pc),
    .cc    (cc),
    .res   (ex_res)
  );

  // register file storage
  always_ff @(posedge clk) begin
    if (ex_write) begin
      regs[ex_res.widx] <= ex_res.wval;
    end
    if (in_fire) begin
      rd1 <= regs[in_sr1];
      rd2 <= regs[in_sr2];
    end
  end

  // operand capture with bypass from the executing item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr <= instruction_word;
      rd1_vld  <= reg_vld[in_sr1];
      rd2_vld  <= reg_vld[in_sr2];
      rd1_fwd  <= ex_write && (ex_res.widx == in_sr1);
      rd2_fwd  <= ex_write && (ex_res.widx == in_sr2);
      fwd_val  <= ex_res.wval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      reg_vld   <= '0;
      pc        <= RESET_PC;
      cc        <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (ex_fire) begin
        s1_valid <= 1'b0;
      end
      if (ex_fire) begin
        out_valid <= 1'b1;
        pc        <= ex_res.next_pc;
        cc        <= ex_res.cc;
        if (ex_res.wrote) begin
          reg_vld[ex_res.widx] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        pc <= start_address;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ex_fire) begin
      next_pc        <= ex_res.next_pc;
      status         <= ex_res.status;
      wrote_register <= ex_res.wrote;
      dest_index     <= ex_res.widx;
      dest_value     <= ex_res.wval;
      cond_flags     <= ex_res.cc;
    end
  end

endmodule
`default_nettype wire

@@ bench/tb_lc3_execute_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lc3_execute_core
// Self-checking bench for the LC-3 execute core. A mirror of the general
// registers, pc and condition code predicts every result when its instruction
// is accepted. Each returned item is compared field by field, in order.
// The run has four phases, each with its own start address and its own mix of
// sender idling and receiver stalls: directed corner cases first, then
// random instruction streams.
// ----------------------------------------------------------------------------
module tb_lc3_execute_core;
  import lc3ex_pkg::*;

  localparam int          CLK_PERIOD    = 20;
  localparam int          RESET_CYCLES  = 8;
  localparam int          NUM_PHASES    = 4;
  localparam int          RANDOM_ITEMS  = 306;
  localparam int          HOLD_CYCLES   = 80;
  localparam int          SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct {
    logic [XLEN-1:0] word;
    bit              drain_first;
  } instr_item_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [XLEN-1:0]     instruction_word;
  logic                out_valid;
  logic                out_ready;
  logic [XLEN-1:0]     next_pc;
  logic                status;
  logic                wrote_register;
  logic [RIDX_W-1:0]   dest_index;
  logic [XLEN-1:0]     dest_value;
  logic [CC_W-1:0]     cond_flags;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [XLEN-1:0]     start_address;

  // architectural state as the bench sees it
  logic [XLEN-1:0]     gpr [NUM_REGS];
  logic [XLEN-1:0]     pc_mirror;
  logic [CC_W-1:0]     cc_mirror;

  instr_item_t         pending_instrs [$];
  ex_result_t          expected_results [$];
  logic [XLEN-1:0]     directed_words [0:26];

  int unsigned         tx_idle_pct  = 0;
  int unsigned         rx_stall_pct = 0;
  bit                  hold_go      = 1'b0;
  bit                  rx_hold;
  int unsigned         mismatches   = 0;
  int unsigned         results_seen = 0;
  int unsigned         items_sent   = 0;
  int unsigned         cycle_count  = 0;

  lc3_execute_core uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .instruction_word (instruction_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .next_pc          (next_pc),
    .status           (status),
    .wrote_register   (wrote_register),
    .dest_index       (dest_index),
    .dest_value       (dest_value),
    .cond_flags       (cond_flags),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .start_address    (start_address)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // executes one instruction on the mirror state and returns what the core
  // should report for it
  function automatic ex_result_t execute_instr(input logic [XLEN-1:0] w);
    ex_result_t      r;
    opcode_t         op;
    logic [XLEN-1:0] operand;
    logic [XLEN-1:0] link;
    op        = opcode_t'(w[15:12]);
    r         = '0;
    pc_mirror = pc_mirror + 1'b1;
    link      = pc_mirror;
    operand   = w[5] ? {{11{w[4]}}, w[4:0]} : gpr[w[2:0]];
    case (op)
      OP_BR: begin
        if ((w[11:9] & cc_mirror) != '0)
          pc_mirror = pc_mirror + {{7{w[8]}}, w[8:0]};
      end
      OP_ADD: begin
        r.wrote = 1'b1;
        r.widx  = w[11:9];
        r.wval  = gpr[w[8:6]] + operand;
      end
      OP_AND: begin
        r.wrote = 1'b1;
        r.widx  = w[11:9];
        r.wval  = gpr[w[8:6]] & operand;
      end
      OP_NOT: begin
        r.wrote = 1'b1;
        r.widx  = w[11:9];
        r.wval  = ~gpr[w[8:6]];
      end
      OP_JMP: begin
        pc_mirror = gpr[w[8:6]];
      end
      OP_JSR: begin
        // base register is read before the link write, so jsrr r7 uses the old r7
        if (w[11])
          pc_mirror = pc_mirror + {{5{w[10]}}, w[10:0]};
        else
          pc_mirror = gpr[w[8:6]];
        r.wrote = 1'b1;
        r.widx  = LINK_REG;
        r.wval  = link;
      end
      default: begin
        r.status = 1'b1;
      end
    endcase
    if (r.wrote) begin
      gpr[r.widx] = r.wval;
      if (op != OP_JSR)
        cc_mirror = (r.wval == '0) ? FLAG_Z : (r.wval[XLEN-1] ? FLAG_N : FLAG_P);
    end
    r.next_pc = pc_mirror;
    r.cc      = cc_mirror;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [XLEN-1:0] exp_v,
                             input logic [XLEN-1:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] %s wrong on result %0d: expected %h, got %h",
                 $time, name, results_seen, exp_v, act_v);
    end
  endtask

  // instruction driver
  always @(posedge clk) begin
    instr_item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(execute_instr(instruction_word));
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct &&
            !(pending_instrs[0].drain_first && expected_results.size() != 0)) begin
          next_item         = pending_instrs.pop_front();
          in_valid         <= 1'b1;
          instruction_word <= next_item.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    ex_result_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result with nothing expected: pc %h wval %h",
                     $time, next_pc, dest_value);
        end else begin
          exp_r = expected_results.pop_front();
          check_field("next_pc", exp_r.next_pc, next_pc);
          check_field("status", XLEN'(exp_r.status), XLEN'(status));
          check_field("wrote_register", XLEN'(exp_r.wrote), XLEN'(wrote_register));
          check_field("dest_index", XLEN'(exp_r.widx), XLEN'(dest_index));
          check_field("dest_value", exp_r.wval, dest_value);
          check_field("cond_flags", XLEN'(exp_r.cc), XLEN'(cond_flags));
        end
      end
      out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off so the pipeline backs up into the input
  initial begin : receiver_holdoff
    int unsigned held;
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++)
      @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : run_sequence
    instr_item_t     item;
    logic [XLEN-1:0] cfg_word;
    rst              = 1'b1;
    in_valid         = 1'b0;
    instruction_word = '0;
    out_ready        = 1'b0;
    cfg_valid        = 1'b0;
    start_address    = '0;
    foreach (gpr[i])
      gpr[i] = '0;
    pc_mirror    = RESET_PC;
    cc_mirror    = '0;

    directed_words = '{
      {OP_BR,  3'b111, 9'h1FF},                   // branch before any flag is set
      {OP_ADD, 3'd1, 3'd0, 1'b1, 5'h0F},
      {OP_ADD, 3'd2, 3'd0, 1'b1, 5'h10},
      {OP_ADD, 3'd3, 3'd1, 1'b0, 2'b11, 3'd2},
      {OP_NOT, 3'd4, 3'd3, 6'h3F},                // low operand bits ignored
      {OP_AND, 3'd5, 3'd3, 1'b1, 5'h1F},
      {OP_AND, 3'd6, 3'd1, 1'b0, 2'b00, 3'd2},
      {OP_BR,  3'b010, 9'h100},
      {OP_BR,  12'h000},                          // no condition bits
      {OP_ADD, 3'd0, 3'd5, 1'b1, 5'h01},          // wraps to zero
      {OP_ADD, 3'd7, 3'd5, 1'b0, 2'b00, 3'd5},
      {OP_BR,  3'b100, 9'h0FF},
      {OP_JSR, 1'b1, 11'h3FF},
      {OP_JSR, 1'b1, 11'h400},
      {OP_JSR, 1'b0, 2'b00, 3'd7, 6'h00},         // jsrr through r7
      {OP_JMP, 3'b000, 3'd7, 6'h00},
      {OP_JMP, 3'b111, 3'd5, 6'h3F},
      {OP_LD,  12'hFFF},
      {OP_ST,  12'h000},
      {OP_LDR, 12'hFFF},
      {OP_STR, 12'h000},
      {OP_RTI, 12'hFFF},
      {OP_LDI, 12'h000},
      {OP_STI, 12'hFFF},
      {OP_RES, 12'h000},
      {OP_LEA, 12'hFFF},
      {OP_TRAP, 12'hFFF}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin cfg_word = 16'hFFFF;       tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin cfg_word = 16'h0000;       tx_idle_pct = 76; rx_stall_pct = 0;  end
        2: begin cfg_word = 16'($urandom);  tx_idle_pct = 0;  rx_stall_pct = 76; end
        default: begin cfg_word = RESET_PC; tx_idle_pct = 33; rx_stall_pct = 33; end
      endcase

      // start address write, only with the core drained
      @(posedge clk);
      cfg_valid     <= 1'b1;
      start_address <= cfg_word;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid    <= 1'b0;
      pc_mirror     = cfg_word;

      @(negedge clk);
      if (phase == 0) begin
        foreach (directed_words[i]) begin
          item.word        = directed_words[i];
          item.drain_first = 1'b0;
          pending_instrs.push_back(item);
        end
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        item.word = 16'($urandom);
        // mostly executed opcodes so register and flag state keeps moving
        if ($urandom_range(0, 99) < 85) begin
          case ($urandom_range(0, 5))
            0:       item.word[15:12] = OP_BR;
            1:       item.word[15:12] = OP_ADD;
            2:       item.word[15:12] = OP_AND;
            3:       item.word[15:12] = OP_NOT;
            4:       item.word[15:12] = OP_JMP;
            default: item.word[15:12] = OP_JSR;
          endcase
        end
        // sender waits for the pipe to empty half way through the phase
        item.drain_first = (i == RANDOM_ITEMS / 2);
        pending_instrs.push_back(item);
      end
      if (phase == 0)
        hold_go = 1'b1;

      while (pending_instrs.size() != 0 || in_valid || expected_results.size() != 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    $display("%0d instructions over %0d phases (start addresses incl. 0xffff and 0x0000,",
             items_sent, NUM_PHASES);
    $display("mixed idling and stalls), %0d results checked, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
